### rtl/core/trf_pkg.sv
package trf_pkg;

   localparam int unsigned SENSOR_W   = 3;
   localparam int unsigned SAMPLE_W   = 12;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned INTERVAL_W = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_LIMIT       = 3'd0,
      CSR_HIGH_LIMIT      = 3'd1,
      CSR_SPIKE_LIMIT     = 3'd2,
      CSR_DEADBAND        = 3'd3,
      CSR_REPORT_INTERVAL = 3'd4
   } csr_index_type;

   localparam logic signed [SAMPLE_W-1:0] LOW_LIMIT_RESET       = -12'sd480;
   localparam logic signed [SAMPLE_W-1:0] HIGH_LIMIT_RESET      = 12'sd1520;
   localparam logic [SAMPLE_W-1:0]        SPIKE_LIMIT_RESET     = 12'd320;
   localparam logic [SAMPLE_W-1:0]        DEADBAND_RESET        = 12'd2;
   localparam logic [INTERVAL_W-1:0]      REPORT_INTERVAL_RESET = 16'd900;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] low_limit;
      logic signed [SAMPLE_W-1:0] high_limit;
      logic [SAMPLE_W-1:0]        spike_limit;
      logic [SAMPLE_W-1:0]        deadband;
      logic [INTERVAL_W-1:0]      report_interval;
   } cfg_type;

   typedef struct packed {
      logic [SENSOR_W-1:0]        sensor;
      logic signed [SAMPLE_W-1:0] sample;
      logic [TIME_W-1:0]          now_seconds;
   } item_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] prev_value;
      logic signed [SAMPLE_W-1:0] valid_value;
      logic [TIME_W-1:0]          valid_time;
      logic [TIME_W-1:0]          report_time;
      logic                       err_mark;
   } entry_type;

   typedef struct packed {
      logic                       report;
      logic [SENSOR_W-1:0]        report_sensor;
      logic signed [SAMPLE_W-1:0] report_value;
      logic                       stale;
      logic                       rejected;
   } result_type;

endpackage

### rtl/core/temperature_report_filter.sv
// a req transfer passes the input register, then the result register, before rsp_valid rises
// throughput: one reading per cycle while rsp_ready is high; per-sensor state is read and
// written back in the same cycle so a reading of the same sensor in the next cycle sees the update
// reset: synchronous, clears both pipeline valid flags, loads the default thresholds and
// zeroes all per-sensor state at once; csr writes are taken in any cycle outside reset
module temperature_report_filter #(
   parameter int unsigned SENSOR_COUNT = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [trf_pkg::SENSOR_W-1:0]         req_sensor,
   input  logic signed [trf_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic [trf_pkg::TIME_W-1:0]           req_now_seconds,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_report,
   output logic [trf_pkg::SENSOR_W-1:0]         rsp_report_sensor,
   output logic signed [trf_pkg::SAMPLE_W-1:0]  rsp_report_value,
   output logic                                 rsp_stale,
   output logic                                 rsp_rejected,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [trf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [trf_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int unsigned IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

   trf_pkg::cfg_type    cfg_ff, cfg_in;
   trf_pkg::item_type   item_ff, item_in;
   logic                in_valid_ff, in_valid_in;
   trf_pkg::result_type result_ff, result_in;
   logic                out_valid_ff, out_valid_in;

   logic                req_xfer;
   logic                advance;
   logic [6:0]          sens_ext;
   logic [IDX_W-1:0]    idx;
   trf_pkg::entry_type  rd_entry;
   trf_pkg::entry_type  upd_entry;
   logic                upd_en;

   // config registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (trf_pkg::csr_index_type'(csr_index))
            trf_pkg::CSR_LOW_LIMIT:       cfg_in.low_limit       = csr_data[11:0];
            trf_pkg::CSR_HIGH_LIMIT:      cfg_in.high_limit      = csr_data[11:0];
            trf_pkg::CSR_SPIKE_LIMIT:     cfg_in.spike_limit     = csr_data[11:0];
            trf_pkg::CSR_DEADBAND:        cfg_in.deadband        = csr_data[11:0];
            trf_pkg::CSR_REPORT_INTERVAL: cfg_in.report_interval = csr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_limit       <= trf_pkg::LOW_LIMIT_RESET;
         cfg_ff.high_limit      <= trf_pkg::HIGH_LIMIT_RESET;
         cfg_ff.spike_limit     <= trf_pkg::SPIKE_LIMIT_RESET;
         cfg_ff.deadband        <= trf_pkg::DEADBAND_RESET;
         cfg_ff.report_interval <= trf_pkg::REPORT_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline control
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   assign item_in = req_xfer ? {req_sensor, req_sample, req_now_seconds} : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= advance ? result_in : result_ff;
   end

   // per-sensor state
   assign sens_ext = {4'b0, item_ff.sensor};
   assign idx      = sens_ext[IDX_W-1:0];

   trf_state #(
      .SENSOR_COUNT (SENSOR_COUNT),
      .IDX_W        (IDX_W)
   ) u_state (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (idx),
      .rd_entry (rd_entry),
      .wr_en    (advance && upd_en),
      .wr_idx   (idx),
      .wr_entry (upd_entry)
   );

   trf_decide #(
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_decide (
      .cfg       (cfg_ff),
      .item      (item_ff),
      .entry     (rd_entry),
      .upd_en    (upd_en),
      .upd_entry (upd_entry),
      .result    (result_in)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_report        = result_ff.report;
   assign rsp_report_sensor = result_ff.report_sensor;
   assign rsp_report_value  = result_ff.report_value;
   assign rsp_stale         = result_ff.stale;
   assign rsp_rejected      = result_ff.rejected;

endmodule

### rtl/core/trf_state.sv
module trf_state #(
   parameter int unsigned SENSOR_COUNT = 8,
   parameter int unsigned IDX_W        = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [IDX_W-1:0]        rd_idx,
   output trf_pkg::entry_type      rd_entry,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_idx,
   input  trf_pkg::entry_type      wr_entry
);

   trf_pkg::entry_type entry_ff [SENSOR_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            entry_ff[i] <= '0;
         end
      end else if (wr_en) begin
         entry_ff[wr_idx] <= wr_entry;
      end
   end

   assign rd_entry = entry_ff[rd_idx];

endmodule

### rtl/core/trf_decide.sv
module trf_decide #(
   parameter int unsigned SENSOR_COUNT = 8
) (
   input  trf_pkg::cfg_type    cfg,
   input  trf_pkg::item_type   item,
   input  trf_pkg::entry_type  entry,
   output logic                upd_en,
   output trf_pkg::entry_type  upd_entry,
   output trf_pkg::result_type result
);

   logic [6:0]  sens_ext;
   logic        in_range;
   logic [12:0] delta;
   logic [12:0] diff;
   logic        out_of_limits;
   logic        spike;
   logic        good;
   logic        dead_report;
   logic [31:0] since_report;
   logic [31:0] since_valid;
   logic        heartbeat;
   trf_pkg::entry_type nxt;

   assign sens_ext = {4'b0, item.sensor};
   assign in_range = sens_ext < 7'(SENSOR_COUNT);

   assign delta = {entry.prev_value[11], entry.prev_value} - {item.sample[11], item.sample};
   assign diff  = delta[12] ? 13'(-delta) : delta;

   assign out_of_limits = (item.sample < cfg.low_limit) || (item.sample > cfg.high_limit);
   assign spike         = (entry.prev_value != '0) && (diff > {1'b0, cfg.spike_limit});
   assign good          = !(out_of_limits || spike);
   assign dead_report   = good && (diff >= {1'b0, cfg.deadband});

   // heartbeat only against the old report time: a deadband report zeroes the elapsed time
   assign since_report = item.now_seconds - entry.report_time;
   assign heartbeat    = !dead_report && (since_report > {16'd0, cfg.report_interval});

   always_comb begin
      nxt = entry;
      if (good) begin
         nxt.valid_value = item.sample;
         nxt.valid_time  = item.now_seconds;
      end
      if (dead_report) begin
         nxt.prev_value  = item.sample;
         nxt.report_time = item.now_seconds;
         nxt.err_mark    = 1'b0;
      end
      if (heartbeat) begin
         nxt.prev_value  = nxt.valid_value;
         nxt.report_time = item.now_seconds;
         nxt.err_mark    = since_valid >= {16'd0, cfg.report_interval};
      end
   end

   assign since_valid = item.now_seconds - (good ? item.now_seconds : entry.valid_time);

   assign upd_en    = in_range;
   assign upd_entry = nxt;

   always_comb begin
      result.report_sensor = item.sensor;
      if (!in_range) begin
         result.report       = 1'b0;
         result.report_value = '0;
         result.stale        = 1'b0;
         result.rejected     = 1'b1;
      end else begin
         result.report       = dead_report || heartbeat;
         result.report_value = dead_report ? item.sample
                             : (heartbeat ? nxt.valid_value : '0);
         result.stale        = nxt.err_mark;
         result.rejected     = !good;
      end
   end

endmodule

### rtl/core/trf_checker.sv
module trf_checker #(
   parameter int unsigned SENSOR_COUNT = 8
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_report,
   input logic [trf_pkg::SENSOR_W-1:0]         rsp_report_sensor,
   input logic signed [trf_pkg::SAMPLE_W-1:0]  rsp_report_value,
   input logic                                 rsp_stale,
   input logic                                 rsp_rejected
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_report_value)
         && $stable(rsp_report) && $stable(rsp_report_sensor))
      else $error("stalled result changed");

   // no transfer carries a value without a report
   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report |-> rsp_report_value == '0)
      else $error("value without report");

   // unknown sensor is rejected and leaves nothing behind
   a_unknown_sensor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ({4'b0, rsp_report_sensor} >= 7'(SENSOR_COUNT))
         |-> rsp_rejected && !rsp_report && !rsp_stale)
      else $error("unknown sensor not rejected");

endmodule

bind temperature_report_filter trf_checker #(
   .SENSOR_COUNT (SENSOR_COUNT)
) u_trf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_report        (rsp_report),
   .rsp_report_sensor (rsp_report_sensor),
   .rsp_report_value  (rsp_report_value),
   .rsp_stale         (rsp_stale),
   .rsp_rejected      (rsp_rejected)
);

### bench/temperature_report_filter_test.sv
module temperature_report_filter_test;

   localparam int N_SENSORS       = 8;
   localparam int N_STEPS         = 22;
   localparam int N_PHASES        = 7;
   localparam int ITEMS_PER_PHASE = 133;
   localparam int STALL_LIMIT     = 2000;

   typedef struct packed {
      trf_pkg::item_type   it;
      logic                known;
      trf_pkg::result_type want;
   } step_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [trf_pkg::SENSOR_W-1:0]    req_sensor;
   logic signed [trf_pkg::SAMPLE_W-1:0] req_sample;
   logic [trf_pkg::TIME_W-1:0]      req_now_seconds;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_report;
   logic [trf_pkg::SENSOR_W-1:0]    rsp_report_sensor;
   logic signed [trf_pkg::SAMPLE_W-1:0] rsp_report_value;
   logic                   rsp_stale;
   logic                   rsp_rejected;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [trf_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [trf_pkg::CSR_DATA_W-1:0]  csr_data;

   // filter thresholds and per-sensor history as the block should hold them
   int          lim_low, lim_high, lim_spike, lim_band;
   logic [31:0] hb_interval;
   int          held_prev [N_SENSORS];
   int          held_valid [N_SENSORS];
   logic [31:0] valid_stamp [N_SENSORS];
   logic [31:0] report_stamp [N_SENSORS];
   logic        stale_mark [N_SENSORS];

   trf_pkg::result_type filter_results_due [$];
   step_row_type plan [N_STEPS];
   int           walk [N_SENSORS];
   logic [31:0]  sim_seconds;
   bit           quiet = 1'b0;
   int           fail_count = 0;
   int           readings_sent = 0;
   int           settings_used = 1;
   int           reports_seen = 0;
   int           rejects_seen = 0;
   int           stale_seen = 0;
   int           idle_cycles = 0;

   temperature_report_filter u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sensor        (req_sensor),
      .req_sample        (req_sample),
      .req_now_seconds   (req_now_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_report        (rsp_report),
      .rsp_report_sensor (rsp_report_sensor),
      .rsp_report_value  (rsp_report_value),
      .rsp_stale         (rsp_stale),
      .rsp_rejected      (rsp_rejected),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int fit(input int v, input int lo, input int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic trf_pkg::result_type filter_reading(input trf_pkg::item_type it);
      trf_pkg::result_type r;
      int         s, smp, gap, shown;
      logic       good;
      s = int'(it.sensor);
      smp = int'($signed(it.sample));
      gap = held_prev[s] - smp;
      if (gap < 0) gap = -gap;
      r = '0;
      shown = 0;
      r.report_sensor = it.sensor;
      good = smp >= lim_low && smp <= lim_high && !(held_prev[s] != 0 && gap > lim_spike);
      if (!good) begin
         r.rejected = 1'b1;
      end else begin
         held_valid[s] = smp;
         valid_stamp[s] = it.now_seconds;
         if (gap >= lim_band) begin
            r.report = 1'b1;
            shown = smp;
            held_prev[s] = smp;
            report_stamp[s] = it.now_seconds;
            stale_mark[s] = 1'b0;
         end
      end
      // heartbeat
      if (it.now_seconds - report_stamp[s] > hb_interval) begin
         r.report = 1'b1;
         shown = held_valid[s];
         held_prev[s] = held_valid[s];
         stale_mark[s] = (it.now_seconds - valid_stamp[s]) >= hb_interval;
         report_stamp[s] = it.now_seconds;
      end
      r.report_value = shown[11:0];
      r.stale = stale_mark[s];
      return r;
   endfunction

   function automatic step_row_type mk_step(input int s, input int v, input logic [31:0] t,
         input logic known, input logic rep, input int val, input logic st, input logic rj);
      step_row_type row;
      row.it.sensor = 3'(s);
      row.it.sample = 12'(v);
      row.it.now_seconds = t;
      row.known = known;
      row.want.report = rep;
      row.want.report_sensor = 3'(s);
      row.want.report_value = 12'(val);
      row.want.stale = st;
      row.want.rejected = rj;
      return row;
   endfunction

   task automatic send_reading(input trf_pkg::item_type it, input logic known,
         input trf_pkg::result_type want);
      trf_pkg::result_type calc;
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sensor <= it.sensor;
      req_sample <= it.sample;
      req_now_seconds <= it.now_seconds;
      do @(posedge clock); while (!req_ready);
      calc = filter_reading(it);
      filter_results_due.push_back(known ? want : calc);
      readings_sent++;
   endtask

   task automatic send_random_reading();
      trf_pkg::item_type it;
      int       roll, s, smp, jolt;
      roll = $urandom_range(0, 99);
      s = $urandom_range(0, N_SENSORS - 1);
      if (roll < 8) sim_seconds += $urandom_range(0, 2 * hb_interval + 16);
      else sim_seconds += $urandom_range(0, 12);
      if (roll < 75) begin
         walk[s] += int'($urandom_range(0, 16)) - 8;
         if (lim_low <= lim_high) walk[s] = fit(walk[s], lim_low, lim_high);
         smp = walk[s];
      end else if (roll < 88) begin
         jolt = lim_spike + int'($urandom_range(1, 40));
         smp = $urandom_range(0, 1) ? walk[s] + jolt : walk[s] - jolt;
      end else begin
         smp = int'($signed(12'($urandom)));
      end
      it.sensor = 3'(s);
      it.sample = 12'(fit(smp, -2048, 2047));
      it.now_seconds = (roll >= 96) ? 32'($urandom) : sim_seconds;
      send_reading(it, 1'b0, '0);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (filter_results_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input trf_pkg::csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         trf_pkg::CSR_LOW_LIMIT:       lim_low = int'($signed(data[11:0]));
         trf_pkg::CSR_HIGH_LIMIT:      lim_high = int'($signed(data[11:0]));
         trf_pkg::CSR_SPIKE_LIMIT:     lim_spike = int'(data[11:0]);
         trf_pkg::CSR_DEADBAND:        lim_band = int'(data[11:0]);
         trf_pkg::CSR_REPORT_INTERVAL: hb_interval = 32'(data);
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] lo, input logic [15:0] hi,
         input logic [15:0] spike, input logic [15:0] band, input logic [15:0] ivl);
      drain_results();
      write_reg(trf_pkg::CSR_LOW_LIMIT, lo);
      write_reg(trf_pkg::CSR_HIGH_LIMIT, hi);
      write_reg(trf_pkg::CSR_SPIKE_LIMIT, spike);
      write_reg(trf_pkg::CSR_DEADBAND, band);
      write_reg(trf_pkg::CSR_REPORT_INTERVAL, ivl);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
         input logic signed [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 22);
   end

   always @(posedge clock) begin
      trf_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_report) reports_seen++;
         if (rsp_rejected) rejects_seen++;
         if (rsp_stale) stale_seen++;
         if (filter_results_due.size() == 0) begin
            fail_count++;
            $display("%0t: result transfer with nothing expected, expected none, %s %0d",
                     $time, "actual sensor", rsp_report_sensor);
         end else begin
            want = filter_results_due.pop_front();
            check_field("report", want.report, rsp_report);
            check_field("report_sensor", want.report_sensor, rsp_report_sensor);
            check_field("report_value", want.report_value, rsp_report_value);
            check_field("stale", want.stale, rsp_stale);
            check_field("rejected", want.rejected, rsp_rejected);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("temperature_report_filter_test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [3:0] junk;
      int         lo_r, hi_r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sensor = '0;
      req_sample = '0;
      req_now_seconds = '0;
      csr_valid = 1'b0;
      csr_index = trf_pkg::CSR_LOW_LIMIT;
      csr_data = '0;
      lim_low = int'(trf_pkg::LOW_LIMIT_RESET);
      lim_high = int'(trf_pkg::HIGH_LIMIT_RESET);
      lim_spike = int'(trf_pkg::SPIKE_LIMIT_RESET);
      lim_band = int'(trf_pkg::DEADBAND_RESET);
      hb_interval = 32'(trf_pkg::REPORT_INTERVAL_RESET);
      for (int s = 0; s < N_SENSORS; s++) begin
         held_prev[s] = 0;
         held_valid[s] = 0;
         valid_stamp[s] = '0;
         report_stamp[s] = '0;
         stale_mark[s] = 1'b0;
      end
      plan = '{
         mk_step(0, 100, 32'd0, 1, 1, 100, 0, 0),
         mk_step(1, -2048, 32'd5, 1, 0, 0, 0, 1),
         mk_step(2, 2047, 32'd10, 1, 0, 0, 0, 1),
         mk_step(0, 500, 32'd20, 1, 0, 0, 0, 1),
         mk_step(0, 101, 32'd30, 1, 0, 0, 0, 0),
         mk_step(0, 101, 32'd1000, 1, 1, 101, 0, 0),
         mk_step(0, -2048, 32'd2000, 1, 1, 101, 1, 1),
         mk_step(0, 105, 32'd2001, 1, 1, 105, 0, 0),
         mk_step(3, 0, 32'hFFFF_FFFF, 1, 1, 0, 0, 0),
         mk_step(3, 5, 32'd10, 1, 1, 5, 0, 0),
         mk_step(7, -480, 32'd900, 1, 1, -480, 0, 0),
         mk_step(7, -481, 32'd901, 1, 0, 0, 0, 1),
         mk_step(6, 1520, 32'd1800, 1, 1, 1520, 0, 0),
         mk_step(6, 1521, 32'd1801, 1, 0, 0, 0, 1),
         mk_step(6, 1200, 32'd1802, 1, 1, 1200, 0, 0),
         mk_step(6, 879, 32'd1803, 1, 0, 0, 0, 1),
         mk_step(5, 0, 32'd900, 1, 0, 0, 0, 0),
         mk_step(5, 0, 32'd901, 1, 1, 0, 0, 0),
         mk_step(5, 2000, 32'd1802, 1, 1, 0, 1, 1),
         mk_step(5, 0, 32'd1803, 1, 0, 0, 1, 0),
         mk_step(4, -1, 32'h8000_0000, 0, 0, 0, 0, 0),
         mk_step(4, -1, 32'h8000_0385, 0, 0, 0, 0, 0)
      };
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_STEPS; i++) begin
         send_reading(plan[i].it, plan[i].known, plan[i].want);
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            1: begin
               // widest limits, zero deadband and zero heartbeat interval: every reading gives a deadband report
               apply_settings(16'h0800, 16'h07FF, 16'h0FFF, 16'h0000, 16'h0000);
               quiet = 1'b1;
            end
            2: begin
               // inverted limits reject everything
               apply_settings(16'h07FF, 16'h0800, 16'h0000, 16'h0FFF, 16'hFFFF);
               quiet = 1'b0;
            end
            3, 4, 5: begin
               lo_r = int'($urandom_range(0, 1600)) - 1800;
               hi_r = fit(lo_r + int'($urandom_range(0, 1800)), -2048, 2047);
               junk = 4'($urandom);
               apply_settings({junk, 12'(lo_r)}, {~junk, 12'(hi_r)},
                              {junk, 12'($urandom_range(0, 400))},
                              {~junk, 12'($urandom_range(0, 20))},
                              16'($urandom_range(0, 2000)));
            end
            6: begin
               apply_settings({4'h0, trf_pkg::LOW_LIMIT_RESET},
                              {4'h0, trf_pkg::HIGH_LIMIT_RESET},
                              {4'h0, trf_pkg::SPIKE_LIMIT_RESET},
                              {4'h0, trf_pkg::DEADBAND_RESET},
                              trf_pkg::REPORT_INTERVAL_RESET);
            end
            default: ;
         endcase
         sim_seconds = $urandom;
         for (int s = 0; s < N_SENSORS; s++) begin
            walk[s] = (lim_low <= lim_high) ?
                      lim_low + int'($urandom_range(0, lim_high - lim_low)) :
                      int'($urandom_range(0, 4095)) - 2048;
         end
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // sender holds off until the pipeline is empty
            if (ph == 0 && i == ITEMS_PER_PHASE / 2) drain_results();
            send_random_reading();
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      $display("covered %0d readings under %0d threshold settings", readings_sent, settings_used);
      $display("seen %0d reports, %0d rejected readings, %0d results with stale mark",
               reports_seen, rejects_seen, stale_seen);
      if (fail_count == 0) begin
         $display("temperature_report_filter_test passed");
      end else begin
         $display("temperature_report_filter_test failed");
      end
      $finish;
   end

endmodule
